[rtl/assert_macros.svh]
// Assertion macros for the checker file of the mouse packet decoder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define PMPD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pmpd: assertion failed");

// Clocked assertion that also holds during reset.
`define PMPD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pmpd: reset assertion failed");

`endif

[rtl/pmpd_pkg.sv]
// Types and constants for the PS/2 mouse packet decoder.
// No dependencies; used by the decoder modules, the checker and the testbench.
package pmpd_pkg;

  // event kinds on the output channel
  localparam logic EV_MOVE   = 1'b0;
  localparam logic EV_BUTTON = 1'b1;

  // button ids
  localparam logic [1:0] BTN_LEFT   = 2'd0;
  localparam logic [1:0] BTN_MIDDLE = 2'd1;
  localparam logic [1:0] BTN_RIGHT  = 2'd2;

  // bit positions in the pending-event mask of a job
  localparam int EVB_MOVE   = 0;
  localparam int EVB_LEFT   = 1;
  localparam int EVB_MIDDLE = 2;
  localparam int EVB_RIGHT  = 3;
  localparam int EV_MASK_W  = 4;

  // status byte bits
  localparam int ST_LEFT   = 0;
  localparam int ST_RIGHT  = 1;
  localparam int ST_MIDDLE = 2;
  localparam int ST_X_SIGN = 4;
  localparam int ST_Y_SIGN = 5;

  localparam logic [1:0] LAST_DATA_BYTE = 2'd2;

  typedef struct packed {
    logic [EV_MASK_W-1:0] mask;     // events still to emit
    logic signed [8:0]    dx;
    logic signed [9:0]    dy;
    logic [2:0]           buttons;  // bit0 left, bit1 middle, bit2 right
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_slot_t;

endpackage

[rtl/pmpd_ifs.sv]
// Valid/ready channel interfaces of the mouse packet decoder.
// No dependencies; plain logic types only.
interface pmpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       from_aux;

  modport source (output valid, output data_byte, output from_aux, input ready);
  modport sink   (input valid, input data_byte, input from_aux, output ready);
endinterface

interface pmpd_evt_if;
  logic              valid;
  logic              ready;
  logic              event_kind;
  logic signed [8:0] delta_x;
  logic signed [9:0] delta_y;
  logic [1:0]        button_id;
  logic              pressed;
  logic              last_event;

  modport source (output valid, output event_kind, output delta_x, output delta_y,
                  output button_id, output pressed, output last_event, input ready);
  modport sink   (input valid, input event_kind, input delta_x, input delta_y,
                  input button_id, input pressed, input last_event, output ready);
endinterface

[rtl/pmpd_front.sv]
// Front end: accepts controller bytes, assembles 3-byte mouse packets and
// turns each complete packet into an event job. Depends on pmpd_pkg, pmpd_ifs.
module pmpd_front (
  input  logic                 clk,
  input  logic                 rst,
  pmpd_byte_if.sink            bytes,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 full,
  output pmpd_pkg::job_slot_t  push
);

  logic       listener;
  logic [1:0] byte_count;
  logic [7:0] pkt0;
  logic [7:0] pkt1;
  logic [2:0] button_state;

  logic              accept;
  logic              pkt_done;
  logic signed [8:0] dx;
  logic signed [9:0] dy;
  logic [2:0]        newb;
  logic [2:0]        changed;
  logic              move;
  logic [pmpd_pkg::EV_MASK_W-1:0] mask;

  assign bytes.ready = !full;
  assign accept      = bytes.valid && bytes.ready && bytes.from_aux;
  // a counter value of three cannot occur; treat it as the last byte anyway
  assign pkt_done    = (byte_count >= pmpd_pkg::LAST_DATA_BYTE);

  always_comb begin
    dx = $signed({pkt0[pmpd_pkg::ST_X_SIGN], pkt1});
    dy = $signed({1'b0, pkt0[pmpd_pkg::ST_Y_SIGN], 8'h00})
       - $signed({2'b00, bytes.data_byte});
    newb = {pkt0[pmpd_pkg::ST_RIGHT], pkt0[pmpd_pkg::ST_MIDDLE], pkt0[pmpd_pkg::ST_LEFT]};
    changed = newb ^ button_state;
    move = (dx != 9'sd0) || (dy != 10'sd0);
    mask = listener ? {changed, move} : '0;
  end

  always_comb begin
    push.valid       = accept && pkt_done && (mask != '0);
    push.job.mask    = mask;
    push.job.dx      = dx;
    push.job.dy      = dy;
    push.job.buttons = newb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      listener     <= 1'b0;
      byte_count   <= '0;
      button_state <= '0;
    end else begin
      if (cfg_we) begin
        listener <= cfg_wdata;
      end
      if (accept) begin
        if (pkt_done) begin
          byte_count   <= '0;
          button_state <= newb;
        end else begin
          byte_count <= byte_count + 2'd1;
        end
      end
    end
  end

  // packet payload bytes, always written before they are read
  always_ff @(posedge clk) begin
    if (accept && !pkt_done) begin
      if (byte_count[0]) begin
        pkt1 <= bytes.data_byte;
      end else begin
        pkt0 <= bytes.data_byte;
      end
    end
  end

endmodule

[rtl/pmpd_queue.sv]
// Short job queue between the packet front end and the event sequencer.
// Depends on pmpd_pkg.
module pmpd_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  pmpd_pkg::job_slot_t push,
  input  logic                pop,
  output logic                full,
  output pmpd_pkg::job_slot_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  pmpd_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_FULL);
  assign head.valid = (count != '0);
  assign head.job   = entries[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.job;
    end
  end

endmodule

[rtl/pmpd_back.sv]
// Back end: takes jobs from the queue and emits their events one per cycle, while
// the receiver keeps up, through an output register. Depends on pmpd_pkg, pmpd_ifs.
module pmpd_back (
  input  logic                clk,
  input  logic                rst,
  input  pmpd_pkg::job_slot_t head,
  output logic                pop,
  pmpd_evt_if.source          events
);

  pmpd_pkg::job_t cur;
  logic [pmpd_pkg::EV_MASK_W-1:0] rem;

  logic [pmpd_pkg::EV_MASK_W-1:0] sel;
  logic [pmpd_pkg::EV_MASK_W-1:0] rem_after;
  logic       slot_free;
  logic       emit;
  logic       sel_kind;
  logic [1:0] sel_id;
  logic       sel_pressed;

  logic              ev_valid;
  logic              ev_kind;
  logic signed [8:0] ev_dx;
  logic signed [9:0] ev_dy;
  logic [1:0]        ev_id;
  logic              ev_pressed;
  logic              ev_last;

  // pick the lowest pending event: move, then left, middle, right
  always_comb begin
    sel         = '0;
    sel_kind    = pmpd_pkg::EV_MOVE;
    sel_id      = pmpd_pkg::BTN_LEFT;
    sel_pressed = 1'b0;
    if (rem[pmpd_pkg::EVB_MOVE]) begin
      sel[pmpd_pkg::EVB_MOVE] = 1'b1;
    end else if (rem[pmpd_pkg::EVB_LEFT]) begin
      sel[pmpd_pkg::EVB_LEFT] = 1'b1;
      sel_kind    = pmpd_pkg::EV_BUTTON;
      sel_id      = pmpd_pkg::BTN_LEFT;
      sel_pressed = cur.buttons[0];
    end else if (rem[pmpd_pkg::EVB_MIDDLE]) begin
      sel[pmpd_pkg::EVB_MIDDLE] = 1'b1;
      sel_kind    = pmpd_pkg::EV_BUTTON;
      sel_id      = pmpd_pkg::BTN_MIDDLE;
      sel_pressed = cur.buttons[1];
    end else if (rem[pmpd_pkg::EVB_RIGHT]) begin
      sel[pmpd_pkg::EVB_RIGHT] = 1'b1;
      sel_kind    = pmpd_pkg::EV_BUTTON;
      sel_id      = pmpd_pkg::BTN_RIGHT;
      sel_pressed = cur.buttons[2];
    end
  end

  assign rem_after = rem & ~sel;
  assign slot_free = !ev_valid || events.ready;
  assign emit      = (rem != '0) && slot_free;
  // fetch the next job as soon as the current one has nothing left after this beat
  assign pop       = head.valid && ((rem == '0) || (emit && (rem_after == '0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      rem      <= '0;
      ev_valid <= 1'b0;
    end else begin
      if (pop) begin
        rem <= head.job.mask;
      end else if (emit) begin
        rem <= rem_after;
      end
      if (emit) begin
        ev_valid <= 1'b1;
      end else if (events.ready) begin
        ev_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.job;
    end
    if (emit) begin
      ev_kind    <= sel_kind;
      ev_dx      <= (sel_kind == pmpd_pkg::EV_MOVE) ? cur.dx : 9'sd0;
      ev_dy      <= (sel_kind == pmpd_pkg::EV_MOVE) ? cur.dy : 10'sd0;
      ev_id      <= sel_id;
      ev_pressed <= sel_pressed;
      ev_last    <= (rem_after == '0);
    end
  end

  assign events.valid      = ev_valid;
  assign events.event_kind = ev_kind;
  assign events.delta_x    = ev_dx;
  assign events.delta_y    = ev_dy;
  assign events.button_id  = ev_id;
  assign events.pressed    = ev_pressed;
  assign events.last_event = ev_last;

endmodule

[rtl/ps2_mouse_packet_decoder.sv]
// PS/2 mouse packet decoder, top level.
// Depends on pmpd_pkg, pmpd_ifs, pmpd_front, pmpd_queue, pmpd_back.
//
// bytes:  one controller data byte per beat, tagged from_aux for mouse bytes.
//         Keyboard beats are accepted and dropped. Every third mouse byte
//         completes a packet (status, X, Y).
// events: per packet, a move event when X or Y is nonzero, then one button
//         event per changed button (left, middle, right); last_event marks
//         the final beat of a packet. Nothing goes out while the listener
//         register is 0, but the button state still tracks the packets.
// cfg_we/cfg_wdata: write the listener register; write only while idle.
// Throughput: one byte per cycle while the job queue has room. A packet's
// events leave one per cycle while the receiver takes them, after passing
// the queue, the sequencer and the output register. The event sequencer
// sets the rate: up to four events per packet, with QUEUE_DEPTH packets
// buffered ahead of it. A stalled receiver holds the output beat; bytes
// keep flowing until the queue fills, then bytes.ready drops.
// Reset (rst, synchronous): packet counter, button state, listener register
// and queue clear; no event is pending.
module ps2_mouse_packet_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  pmpd_byte_if.sink  bytes,
  pmpd_evt_if.source events,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  pmpd_pkg::job_slot_t push;
  pmpd_pkg::job_slot_t head;
  logic                full;
  logic                pop;

  pmpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .full      (full),
    .push      (push)
  );

  pmpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  pmpd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .events (events)
  );

endmodule

[rtl/pmpd_checker.sv]
// Port-level checker for the mouse packet decoder, bound to the top level.
// Depends on assert_macros.svh and pmpd_pkg.
`include "assert_macros.svh"

module pmpd_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              event_kind,
  input logic signed [8:0] delta_x,
  input logic signed [9:0] delta_y,
  input logic [1:0]        button_id,
  input logic              pressed,
  input logic              last_event
);

  logic        move_beat;
  logic        has_delta;
  logic        mid_accept;
  logic        button_beat;
  logic        stalled;
  logic [23:0] beat_bits;

  assign move_beat   = out_valid && (event_kind == pmpd_pkg::EV_MOVE);
  assign has_delta   = (delta_x != 9'sd0) || (delta_y != 10'sd0);
  assign mid_accept  = out_valid && out_ready && !last_event;
  assign button_beat = out_valid && (event_kind == pmpd_pkg::EV_BUTTON);
  assign stalled     = out_valid && !out_ready;
  assign beat_bits   = {event_kind, delta_x, delta_y, button_id, pressed, last_event};

  // no beat pending right after reset
  `PMPD_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid)

  // a move beat always carries some movement
  `PMPD_ASSERT(a_move_nonzero, clk, rst, move_beat |-> has_delta)

  // a packet's events stream without gaps; anything after the first is a button
  `PMPD_ASSERT(a_packet_stream, clk, rst, mid_accept |=> button_beat)

  // a stalled beat holds
  `PMPD_ASSERT(a_stall_hold, clk, rst, stalled |=> (out_valid && $stable(beat_bits)))

endmodule

bind ps2_mouse_packet_decoder pmpd_checker u_pmpd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (events.valid),
  .out_ready  (events.ready),
  .event_kind (events.event_kind),
  .delta_x    (events.delta_x),
  .delta_y    (events.delta_y),
  .button_id  (events.button_id),
  .pressed    (events.pressed),
  .last_event (events.last_event)
);

[bench/tb_ps2_mouse_packet_decoder.sv]
// Testbench for the PS/2 mouse packet decoder: drives byte beats, predicts the events.
// Depends on pmpd_pkg, pmpd_ifs and the ps2_mouse_packet_decoder RTL.
module tb_ps2_mouse_packet_decoder;

  localparam int SETTLE_CYCLES = 20;
  localparam int QUIET_LIMIT   = 2000;
  localparam int IDLE_PCT      = 24;

  typedef struct packed {
    logic              kind;
    logic signed [8:0] dx;
    logic signed [9:0] dy;
    logic [1:0]        btn;
    logic              pressed;
    logic              last;
  } mouse_event_t;

  // Tracks packet assembly and button state, and holds the events still due.
  class mouse_event_board;
    bit             listening = 1'b0;
    bit [1:0]       bytes_held = 2'd0;
    bit [7:0]       status_byte = 8'h00;
    bit [7:0]       x_byte = 8'h00;
    bit [2:0]       buttons = 3'b000;
    logic [1:0]     btn_order [3] = '{pmpd_pkg::BTN_LEFT, pmpd_pkg::BTN_MIDDLE,
                                      pmpd_pkg::BTN_RIGHT};
    mouse_event_t   due_events[$];
    int             errors = 0;

    function int pending();
      return due_events.size();
    endfunction

    function void take_byte(bit [7:0] d, bit aux);
      mouse_event_t ev;
      bit [2:0]     now_down;
      bit [8:0]     dx;
      bit [9:0]     dy;
      int           first;
      if (!aux) return;
      if (bytes_held < 2'd2) begin
        if (bytes_held == 2'd0) status_byte = d;
        else x_byte = d;
        bytes_held++;
        return;
      end
      bytes_held = 2'd0;
      dx = {status_byte[pmpd_pkg::ST_X_SIGN], x_byte};
      // negate Y so that up is negative
      dy = (status_byte[pmpd_pkg::ST_Y_SIGN] ? 10'd256 : 10'd0) - {2'b00, d};
      now_down = {status_byte[pmpd_pkg::ST_RIGHT], status_byte[pmpd_pkg::ST_MIDDLE],
                  status_byte[pmpd_pkg::ST_LEFT]};
      first = due_events.size();
      if (listening && (dx != 0 || dy != 0)) begin
        ev = '{pmpd_pkg::EV_MOVE, dx, dy, 2'd0, 1'b0, 1'b0};
        due_events.push_back(ev);
      end
      for (int i = 0; i < 3; i++) begin
        if (listening && now_down[i] != buttons[i]) begin
          ev = '{pmpd_pkg::EV_BUTTON, 9'd0, 10'd0, btn_order[i], now_down[i], 1'b0};
          due_events.push_back(ev);
        end
      end
      buttons = now_down;
      if (due_events.size() > first) due_events[due_events.size()-1].last = 1'b1;
    endfunction

    function void diff_field(string field, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void match_event(mouse_event_t got);
      mouse_event_t want;
      if (due_events.size() == 0) begin
        $error("event beat with none expected: kind %0d", got.kind);
        errors++;
        return;
      end
      want = due_events.pop_front();
      diff_field("event_kind", want.kind, got.kind);
      diff_field("delta_x", $signed(want.dx), $signed(got.dx));
      diff_field("delta_y", $signed(want.dy), $signed(got.dy));
      diff_field("button_id", want.btn, got.btn);
      diff_field("pressed", want.pressed, got.pressed);
      diff_field("last_event", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  pmpd_byte_if bif ();
  pmpd_evt_if  eif ();

  mouse_event_board board = new();

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_cnt   = 0;
  bit [1:0] mouse_pos = 2'd0;

  ps2_mouse_packet_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bif),
    .events    (eif),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && bif.valid && bif.ready) board.take_byte(bif.data_byte, bif.from_aux);
    if (!rst && eif.valid && eif.ready) begin
      board.match_event('{eif.event_kind, eif.delta_x, eif.delta_y, eif.button_id,
                          eif.pressed, eif.last_event});
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    eif.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        eif.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        eif.ready <= 1'b0;
        hold_cnt--;
      end else begin
        eif.ready <= !rx_idle_on || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((bif.valid && bif.ready) || (eif.valid && eif.ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] d, input logic aux);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      bif.valid <= 1'b0;
      @(posedge clk);
    end
    bif.valid     <= 1'b1;
    bif.data_byte <= d;
    bif.from_aux  <= aux;
    do @(posedge clk); while (!bif.ready);
  endtask

  task automatic send_packet(input logic [7:0] status, input logic [7:0] x,
                             input logic [7:0] y);
    send_byte(status, 1'b1);
    send_byte(x, 1'b1);
    send_byte(y, 1'b1);
  endtask

  // Drop valid, wait out every due event, then let the block settle.
  task automatic wait_idle();
    bif.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_listener(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    board.listening = v;
    cfg_we <= 1'b0;
  endtask

  // Lean toward zero and the extremes so zero-delta packets show up often.
  function automatic logic [7:0] pick_delta();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 8'h00;
    if (r < 28) return 8'hFF;
    if (r < 32) return 8'h80;
    return 8'($urandom);
  endfunction

  task automatic send_random();
    logic [7:0] d;
    if ($urandom_range(99) < 12) begin
      send_byte(8'($urandom), 1'b0);
      return;
    end
    case (mouse_pos)
      2'd0: begin
        d = 8'($urandom);
        if ($urandom_range(99) < 40) begin
          d[pmpd_pkg::ST_X_SIGN] = 1'b0;
          d[pmpd_pkg::ST_Y_SIGN] = 1'b0;
        end
      end
      default: d = pick_delta();
    endcase
    send_byte(d, 1'b1);
    mouse_pos = (mouse_pos == 2'd2) ? 2'd0 : mouse_pos + 2'd1;
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= 1'b0;
    bif.valid     <= 1'b0;
    bif.data_byte <= 8'h00;
    bif.from_aux  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: listener on, extremes of both deltas, every button edge
    write_listener(1'b1);
    send_byte(8'hFF, 1'b0);
    send_packet(8'h08, 8'h00, 8'h00);
    send_byte(8'h00, 1'b0);
    send_packet(8'hFF, 8'h00, 8'h00);
    send_packet(8'h08, 8'hFF, 8'hFF);
    send_byte(8'h01, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b1);
    send_packet(8'h02, 8'h00, 8'h00);
    send_packet(8'h04, 8'h00, 8'h80);
    send_packet(8'h30, 8'h00, 8'h00);
    wait_idle();

    // no listener: state still tracks, nothing comes out
    write_listener(1'b0);
    repeat (20) send_random();
    wait_idle();

    write_listener(1'b1);
    for (int n = 0; n < 86; n++) begin
      tx_idle_on = !(n >= 30 && n < 65);
      rx_idle_on = tx_idle_on;
      if (n == 50) hold_cnt = 80;
      send_random();
    end
    wait_idle();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
